>>> rtl/mouse_keys_accelerator_core_macros.svh
// assertion macros for the mouse keys accelerator checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef MOUSE_KEYS_ACCELERATOR_CORE_MACROS_SVH
`define MOUSE_KEYS_ACCELERATOR_CORE_MACROS_SVH

// same-cycle implication
`define MKACC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mkacc: same-cycle check failed");

// next-cycle implication
`define MKACC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mkacc: next-cycle check failed");

`endif

>>> rtl/mkacc_pkg.sv
// shared types, codes and constants of the mouse keys accelerator
// no dependencies
package mkacc_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned SpeedW    = 6;
  localparam int unsigned KeyW      = 4;
  localparam int unsigned BtnW      = 5;
  localparam int unsigned MaskW     = 4;
  localparam int unsigned MotionW   = 8;
  localparam int unsigned ScrollW   = 2;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ProdW     = SpeedW + IntervalW;
  localparam int unsigned DivCntW   = $clog2(ProdW + 1);

  // divide by three as multiply by 171 and shift by 9, exact below 512
  localparam int unsigned SlowRecipW = 8;
  localparam int unsigned SlowShift  = 9;
  localparam logic [SlowRecipW-1:0] SlowRecip = 8'd171;

  localparam logic [IntervalW-1:0] AccelDelayRst     = 16'd150;
  localparam logic [SpeedW-1:0]    BaseSpeedRst      = 6'd2;
  localparam logic [SpeedW-1:0]    TopSpeedRst       = 6'd10;
  localparam logic [IntervalW-1:0] RampTimeRst       = 16'd600;
  localparam logic [IntervalW-1:0] MoveIntervalRst   = 16'd16;
  localparam logic [IntervalW-1:0] ScrollIntervalRst = 16'd90;

  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_DELAY,
    CFG_BASE_SPEED,
    CFG_TOP_SPEED,
    CFG_RAMP_TIME,
    CFG_MOVE_INTERVAL,
    CFG_SCROLL_INTERVAL
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_SLOW,
    MODE_FAST
  } speed_mode_e;

  typedef enum logic [KeyW-1:0] {
    KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT,
    KEY_BTN1, KEY_BTN2, KEY_BTN3, KEY_BTN4, KEY_BTN5,
    KEY_WH_UP, KEY_WH_DOWN, KEY_WH_LEFT, KEY_WH_RIGHT,
    KEY_ACCEL0, KEY_ACCEL1, KEY_ACCEL2
  } key_code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ROUTE,
    ST_LOAD,
    ST_DIV,
    ST_MOVE,
    ST_SCROLL
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic key_apply;
    logic tick_eval;
    logic ramp_prep;
    logic div_start;
    logic speed_load;
    logic move_emit;
    logic scroll_emit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic key_has_result;
    logic slot_free;
    logic move_due;
    logic scroll_due;
    logic move_nonzero;
    logic div_busy;
  } dp_status_t;

endpackage

>>> rtl/mkacc_div.sv
// restoring divider for the speed ramp, one quotient bit per cycle
// depends on mkacc_pkg
module mkacc_div import mkacc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ProdW-1:0]     dividend_i,
  input  logic [IntervalW-1:0] divisor_i,
  output logic                 busy_o,
  output logic [SpeedW-1:0]    quotient_o
);

  logic                 busy_q;
  logic [DivCntW-1:0]   cnt_q;
  logic [IntervalW-1:0] rem_q, rem_d;
  logic [ProdW-1:0]     quo_q, quo_d;
  logic [IntervalW-1:0] divisor_q;
  logic [IntervalW:0]   trial;
  logic                 ge;

  always_comb begin
    trial = {rem_q, quo_q[ProdW-1]};
    ge    = trial >= {1'b0, divisor_q};
    rem_d = ge ? IntervalW'(trial - {1'b0, divisor_q}) : trial[IntervalW-1:0];
    quo_d = {quo_q[ProdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DivCntW'(ProdW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[SpeedW-1:0];

endmodule

>>> rtl/mkacc_ctrl.sv
// sequencer of the mouse keys accelerator: input handshake and datapath commands
// depends on mkacc_pkg
module mkacc_ctrl import mkacc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t stat_i,
  output dp_cmd_t    ctrl_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (stat_i.is_tick) begin
          ctrl_o.tick_eval = 1'b1;
          state_d          = ST_ROUTE;
        end else if (!stat_i.key_has_result || stat_i.slot_free) begin
          ctrl_o.key_apply = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_ROUTE: begin
        ctrl_o.ramp_prep = 1'b1;
        if (stat_i.move_due) begin
          state_d = ST_LOAD;
        end else if (stat_i.scroll_due) begin
          state_d = ST_SCROLL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LOAD: begin
        ctrl_o.div_start = 1'b1;
        state_d          = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          ctrl_o.speed_load = 1'b1;
          state_d           = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (!stat_i.move_nonzero || stat_i.slot_free) begin
          ctrl_o.move_emit = stat_i.move_nonzero;
          state_d          = stat_i.scroll_due ? ST_SCROLL : ST_IDLE;
        end
      end
      ST_SCROLL: begin
        if (stat_i.slot_free) begin
          ctrl_o.scroll_emit = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mkacc_dp.sv
// datapath of the mouse keys accelerator: registers, key decode, timing, speed, result register
// depends on mkacc_pkg and mkacc_div
module mkacc_dp import mkacc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  input  logic                        cmd_i,
  input  logic [KeyW-1:0]             key_code_i,
  input  logic                        pressed_i,
  input  logic [TimeW-1:0]            time_ms_i,
  input  dp_cmd_t                     ctrl_i,
  output dp_status_t                  stat_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        has_report_o,
  output logic [BtnW-1:0]             buttons_o,
  output logic signed [MotionW-1:0]   dx_o,
  output logic signed [MotionW-1:0]   dy_o,
  output logic signed [ScrollW-1:0]   wheel_o,
  output logic signed [ScrollW-1:0]   pan_o,
  output logic                        idle_o,
  output logic                        last_o
);

  function automatic logic [MotionW-1:0] dir_step(input logic pos, input logic neg,
                                                  input logic [MotionW-1:0] mag);
    logic [MotionW-1:0] p;
    logic [MotionW-1:0] n;
    p = pos ? mag : '0;
    n = neg ? mag : '0;
    return p - n;
  endfunction

  function automatic logic [ScrollW-1:0] unit_step(input logic pos, input logic neg);
    logic [ScrollW-1:0] p;
    logic [ScrollW-1:0] n;
    p = pos ? ScrollW'(1) : '0;
    n = neg ? ScrollW'(1) : '0;
    return p - n;
  endfunction

  logic [IntervalW-1:0] accel_delay_q, ramp_time_q, move_interval_q, scroll_interval_q;
  logic [SpeedW-1:0]    base_speed_q, top_speed_q;

  logic                 item_cmd_q;
  key_code_e            item_key_q;
  logic                 item_pressed_q;
  logic [TimeW-1:0]     item_time_q;

  logic [BtnW-1:0]      buttons_q;
  logic [MaskW-1:0]     move_mask_q, scroll_mask_q;
  speed_mode_e          mode_q;
  logic                 moving_q;
  logic [TimeW-1:0]     move_start_q, last_move_q, last_scroll_q;

  logic                 move_due_q, scroll_due_q, in_delay_q;
  logic [TimeW-1:0]     elapsed_q;
  logic [IntervalW-1:0] active_q;
  logic [SpeedW:0]      speed_q;

  logic                 out_valid_q, out_last_q, out_idle_q;
  logic [BtnW-1:0]      out_buttons_q;
  logic [MotionW-1:0]   out_dx_q, out_dy_q;
  logic [ScrollW-1:0]   out_wheel_q, out_pan_q;

  // key event decode
  logic [KeyW-1:0]      btn_off, whl_off;
  logic [MaskW-1:0]     dir_bit, whl_bit;
  logic [BtnW-1:0]      btn_bit;
  logic [BtnW-1:0]      k_buttons;
  logic [MaskW-1:0]     k_move, k_scroll;
  speed_mode_e          k_mode;
  logic                 k_moving, k_set_move_t, k_set_scroll_t, k_has;
  logic [MotionW-1:0]   k_dx, k_dy;
  logic [ScrollW-1:0]   k_wheel, k_pan;

  assign btn_off = KeyW'(item_key_q - KEY_BTN1);
  assign whl_off = KeyW'(item_key_q - KEY_WH_UP);
  assign dir_bit = MaskW'(1) << item_key_q[1:0];
  assign btn_bit = BtnW'(1) << btn_off[2:0];
  assign whl_bit = MaskW'(1) << whl_off[1:0];

  always_comb begin
    k_buttons      = buttons_q;
    k_move         = move_mask_q;
    k_scroll       = scroll_mask_q;
    k_mode         = mode_q;
    k_moving       = moving_q;
    k_set_move_t   = 1'b0;
    k_set_scroll_t = 1'b0;
    k_has          = 1'b0;
    k_dx           = '0;
    k_dy           = '0;
    k_wheel        = '0;
    k_pan          = '0;
    case (item_key_q) inside
      [KEY_UP:KEY_RIGHT]: begin
        k_move = item_pressed_q ? (move_mask_q | dir_bit) : (move_mask_q & ~dir_bit);
        if (k_move != '0) begin
          if (!moving_q) begin
            k_moving     = 1'b1;
            k_set_move_t = 1'b1;
            k_dx         = dir_step(k_move[3], k_move[2], MotionW'(1));
            k_dy         = dir_step(k_move[1], k_move[0], MotionW'(1));
            k_has        = (k_dx != '0) || (k_dy != '0);
          end
        end else begin
          k_moving = 1'b0;
        end
      end
      [KEY_BTN1:KEY_BTN5]: begin
        k_buttons = item_pressed_q ? (buttons_q | btn_bit) : (buttons_q & ~btn_bit);
        k_has     = k_buttons != buttons_q;
      end
      [KEY_WH_UP:KEY_WH_RIGHT]: begin
        if (item_pressed_q) begin
          k_scroll       = scroll_mask_q | whl_bit;
          k_has          = 1'b1;
          k_set_scroll_t = 1'b1;
          k_wheel        = unit_step(whl_off[1:0] == 2'd0, whl_off[1:0] == 2'd1);
          k_pan          = unit_step(whl_off[1:0] == 2'd3, whl_off[1:0] == 2'd2);
        end else begin
          k_scroll = scroll_mask_q & ~whl_bit;
        end
      end
      KEY_ACCEL0: k_mode = item_pressed_q ? MODE_SLOW : MODE_NORMAL;
      KEY_ACCEL1: k_mode = MODE_NORMAL;
      KEY_ACCEL2: k_mode = item_pressed_q ? MODE_FAST : MODE_NORMAL;
      default: k_mode = mode_q;
    endcase
  end

  // tick timing
  logic [TimeW-1:0]   move_gap, scroll_gap, elapsed_c, active_c;
  logic               move_due_c, scroll_due_c;
  logic [ScrollW-1:0] rep_wheel, rep_pan;

  assign move_gap     = item_time_q - last_move_q;
  assign scroll_gap   = item_time_q - last_scroll_q;
  assign elapsed_c    = item_time_q - move_start_q;
  assign move_due_c   = (move_mask_q != '0) && (move_gap >= TimeW'(move_interval_q));
  assign scroll_due_c = (scroll_mask_q != '0) && (scroll_gap >= TimeW'(scroll_interval_q));
  assign rep_wheel    = unit_step(scroll_mask_q[0], scroll_mask_q[1]);
  assign rep_pan      = unit_step(scroll_mask_q[3], scroll_mask_q[2]);
  assign active_c     = elapsed_q - TimeW'(accel_delay_q);

  // speed ramp
  logic [SpeedW-1:0]            diff, quot, ramp_add;
  logic [ProdW-1:0]             prod;
  logic [SpeedW:0]              sum, speed_c;
  logic [SpeedW+SlowRecipW:0]   slow_prod;
  logic                         div_busy;

  assign diff      = (top_speed_q > base_speed_q) ? SpeedW'(top_speed_q - base_speed_q) : '0;
  assign prod      = ProdW'(diff) * ProdW'(active_q);
  assign ramp_add  = (ramp_time_q == '0) ? diff : quot;
  assign sum       = {1'b0, base_speed_q} + {1'b0, ramp_add};
  assign slow_prod = (SpeedW+SlowRecipW+1)'(sum) * (SpeedW+SlowRecipW+1)'(SlowRecip);

  always_comb begin
    if (in_delay_q) begin
      speed_c = {1'b0, base_speed_q};
    end else begin
      case (mode_q)
        MODE_SLOW: speed_c = (sum > (SpeedW+1)'(2))
                             ? (SpeedW+1)'(slow_prod[SpeedW+SlowRecipW:SlowShift])
                             : (SpeedW+1)'(1);
        MODE_FAST: speed_c = {sum[SpeedW-1:0], 1'b0};
        default:   speed_c = sum;
      endcase
    end
  end

  mkacc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (prod),
    .divisor_i  (ramp_time_q),
    .busy_o     (div_busy),
    .quotient_o (quot)
  );

  logic [MotionW-1:0] mv_dx, mv_dy;
  logic               mv_nonzero;

  assign mv_dx      = dir_step(move_mask_q[3], move_mask_q[2], MotionW'(speed_q));
  assign mv_dy      = dir_step(move_mask_q[1], move_mask_q[0], MotionW'(speed_q));
  assign mv_nonzero = (mv_dx != '0) || (mv_dy != '0);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_delay_q     <= AccelDelayRst;
      base_speed_q      <= BaseSpeedRst;
      top_speed_q       <= TopSpeedRst;
      ramp_time_q       <= RampTimeRst;
      move_interval_q   <= MoveIntervalRst;
      scroll_interval_q <= ScrollIntervalRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ACCEL_DELAY:     accel_delay_q     <= cfg_data_i;
        CFG_BASE_SPEED:      base_speed_q      <= cfg_data_i[SpeedW-1:0];
        CFG_TOP_SPEED:       top_speed_q       <= cfg_data_i[SpeedW-1:0];
        CFG_RAMP_TIME:       ramp_time_q       <= cfg_data_i;
        CFG_MOVE_INTERVAL:   move_interval_q   <= cfg_data_i;
        CFG_SCROLL_INTERVAL: scroll_interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buttons_q     <= '0;
      move_mask_q   <= '0;
      scroll_mask_q <= '0;
      mode_q        <= MODE_NORMAL;
      moving_q      <= 1'b0;
      move_start_q  <= '0;
      last_move_q   <= '0;
      last_scroll_q <= '0;
      move_due_q    <= 1'b0;
      scroll_due_q  <= 1'b0;
    end else if (ctrl_i.key_apply) begin
      buttons_q     <= k_buttons;
      move_mask_q   <= k_move;
      scroll_mask_q <= k_scroll;
      mode_q        <= k_mode;
      moving_q      <= k_moving;
      if (k_set_move_t) begin
        move_start_q <= item_time_q;
        last_move_q  <= item_time_q;
      end
      if (k_set_scroll_t) begin
        last_scroll_q <= item_time_q;
      end
    end else if (ctrl_i.tick_eval) begin
      move_due_q   <= move_due_c;
      scroll_due_q <= scroll_due_c && ((rep_wheel != '0) || (rep_pan != '0));
      if (move_due_c) begin
        last_move_q <= item_time_q;
      end
      if (scroll_due_c) begin
        last_scroll_q <= item_time_q;
      end
    end
  end

  // item and speed working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      item_cmd_q     <= cmd_i;
      item_key_q     <= key_code_e'(key_code_i);
      item_pressed_q <= pressed_i;
      item_time_q    <= time_ms_i;
    end
    if (ctrl_i.tick_eval) begin
      elapsed_q <= elapsed_c;
    end
    if (ctrl_i.ramp_prep) begin
      in_delay_q <= elapsed_q < TimeW'(accel_delay_q);
      active_q   <= (active_c > TimeW'(ramp_time_q)) ? ramp_time_q : active_c[IntervalW-1:0];
    end
    if (ctrl_i.speed_load) begin
      speed_q <= speed_c;
    end
  end

  // result register
  logic load_key, load_out, slot_free;

  assign load_key  = ctrl_i.key_apply && k_has;
  assign load_out  = load_key || ctrl_i.move_emit || ctrl_i.scroll_emit;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_key) begin
      out_buttons_q <= k_buttons;
      out_dx_q      <= k_dx;
      out_dy_q      <= k_dy;
      out_wheel_q   <= k_wheel;
      out_pan_q     <= k_pan;
      out_idle_q    <= (k_move == '0) && (k_scroll == '0);
      out_last_q    <= 1'b1;
    end else if (ctrl_i.move_emit) begin
      out_buttons_q <= buttons_q;
      out_dx_q      <= mv_dx;
      out_dy_q      <= mv_dy;
      out_wheel_q   <= '0;
      out_pan_q     <= '0;
      out_idle_q    <= (move_mask_q == '0) && (scroll_mask_q == '0);
      out_last_q    <= !scroll_due_q;
    end else if (ctrl_i.scroll_emit) begin
      out_buttons_q <= buttons_q;
      out_dx_q      <= '0;
      out_dy_q      <= '0;
      out_wheel_q   <= rep_wheel;
      out_pan_q     <= rep_pan;
      out_idle_q    <= (move_mask_q == '0) && (scroll_mask_q == '0);
      out_last_q    <= 1'b1;
    end
  end

  assign stat_o.is_tick        = item_cmd_q == CMD_TICK;
  assign stat_o.key_has_result = k_has;
  assign stat_o.slot_free      = slot_free;
  assign stat_o.move_due       = move_due_q;
  assign stat_o.scroll_due     = scroll_due_q;
  assign stat_o.move_nonzero   = mv_nonzero;
  assign stat_o.div_busy       = div_busy;

  assign out_valid_o  = out_valid_q;
  assign has_report_o = 1'b1;
  assign buttons_o    = out_buttons_q;
  assign dx_o         = $signed(out_dx_q);
  assign dy_o         = $signed(out_dy_q);
  assign wheel_o      = $signed(out_wheel_q);
  assign pan_o        = $signed(out_pan_q);
  assign idle_o       = out_idle_q;
  assign last_o       = out_last_q;

endmodule

>>> rtl/mouse_keys_accelerator_core.sv
// top level of the mouse keys accelerator: sequencer plus datapath
// depends on mkacc_pkg, mkacc_ctrl, mkacc_dp
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_stall_o   cmd_i key_code_i pressed_i time_ms_i
// out      out  out_valid_o / out_stall_i has_report_o buttons_o dx_o dy_o wheel_o pan_o
//                                         idle_o last_o
// cfg      in   cfg_we_i                  cfg_index_i cfg_data_i
//
// a key event is decoded after transfer and its result loaded once the output slot is free
// a tick with a due cursor step passes the decode, route and load states and the 22-step ramp
// divider before the move state loads its first result
// one item is worked on at a time; the next is taken while the last result waits
// a stalled output holds the second result of a tick in the sequencer
// rst_ni is asynchronous and restores the default register values
module mouse_keys_accelerator_core import mkacc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]       cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [KeyW-1:0]           key_code_i,
  input  logic                      pressed_i,
  input  logic [TimeW-1:0]          time_ms_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      has_report_o,
  output logic [BtnW-1:0]           buttons_o,
  output logic signed [MotionW-1:0] dx_o,
  output logic signed [MotionW-1:0] dy_o,
  output logic signed [ScrollW-1:0] wheel_o,
  output logic signed [ScrollW-1:0] pan_o,
  output logic                      idle_o,
  output logic                      last_o
);

  dp_cmd_t    ctrl;
  dp_status_t stat;

  mkacc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  mkacc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd_i),
    .key_code_i   (key_code_i),
    .pressed_i    (pressed_i),
    .time_ms_i    (time_ms_i),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .has_report_o (has_report_o),
    .buttons_o    (buttons_o),
    .dx_o         (dx_o),
    .dy_o         (dy_o),
    .wheel_o      (wheel_o),
    .pan_o        (pan_o),
    .idle_o       (idle_o),
    .last_o       (last_o)
  );

endmodule

>>> rtl/mkacc_checker.sv
// port-level checks of the mouse keys accelerator, bound to the top level
// depends on mkacc_pkg and mouse_keys_accelerator_core_macros.svh
`include "mouse_keys_accelerator_core_macros.svh"

module mkacc_checker import mkacc_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      has_report_o,
  input logic signed [MotionW-1:0] dx_o,
  input logic signed [MotionW-1:0] dy_o,
  input logic signed [ScrollW-1:0] wheel_o,
  input logic signed [ScrollW-1:0] pan_o,
  input logic                      last_o
);

  `MKACC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(dx_o) && $stable(dy_o) && $stable(wheel_o) && $stable(pan_o)
    && $stable(last_o))
  `MKACC_ASSERT_NEXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o)
  `MKACC_ASSERT_NOW(a_motion_no_scroll, out_valid_o && (dx_o != 0 || dy_o != 0),
    wheel_o == 0 && pan_o == 0)
  `MKACC_ASSERT_NOW(a_unit_scroll, out_valid_o,
    wheel_o != 2'b10 && pan_o != 2'b10 && has_report_o)

endmodule

bind mouse_keys_accelerator_core mkacc_checker u_mkacc_checker (.*);
